### hw/rtl/elbm_pkg.sv
// ----------------------------------------------------------------------------
// elbm_pkg: shared types and constants of the EWMA level band monitor
// Register map, fixed-point widths and the configuration bundle.
// ----------------------------------------------------------------------------
package elbm_pkg;

	localparam int MAX_BANDS = 6;
	localparam int LEVEL_W   = 32;
	localparam int FRAC_W    = 16;
	localparam int ACC_W     = LEVEL_W + FRAC_W;
	localparam int ALPHA_W   = FRAC_W + 1;
	localparam int BAND_W    = 3;
	localparam int NREGS     = 2 + MAX_BANDS;
	localparam int ADDR_W    = $clog2(NREGS * 4);
	localparam int IDX_W     = $clog2(NREGS);

	localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(1) << FRAC_W;
	localparam logic [BAND_W-1:0]  NO_BAND   = BAND_W'(MAX_BANDS);
	localparam logic [BAND_W-1:0]  BANDS_MAX = BAND_W'(MAX_BANDS);

	// register indexes
	localparam logic [IDX_W-1:0] REG_ALPHA  = IDX_W'(0);
	localparam logic [IDX_W-1:0] REG_COUNT  = IDX_W'(1);
	localparam logic [IDX_W-1:0] REG_LIMIT0 = IDX_W'(2);

	typedef struct packed {
		logic [ALPHA_W-1:0]                 alpha;
		logic [BAND_W-1:0]                  band_count;
		logic [MAX_BANDS-1:0][LEVEL_W-1:0]  limit;
	} cfg_t;

	// control of the stage that holds the freshly updated average
	typedef struct packed {
		logic vld;
		logic bad;
	} stage_t;

endpackage

### hw/rtl/ewma_level_band_monitor.sv
// ----------------------------------------------------------------------------
// ewma_level_band_monitor: smoothed level classifier
// Each item carries one level sample or a bad-sample mark and yields exactly
// one result item. A good sample moves a Q32.16 running average toward it by
// the weight alpha (Q1.16, 65536 = no smoothing); the average is then checked
// against up to six ascending band limits and the first limit it does not
// exceed names the current band. A move into another band pushes the old one
// into band_before and raises band_changed. A bad sample leaves everything
// alone and reports the held values. Band index 6 means no band yet. The block
// takes one item per clock cycle while in_ready is high; each item passes the
// input register, then the average register, then the result register. The
// rate rests on the loop of the average through its 48x17 multiplier. A
// result that waits on out_ready does not stop the block from taking items
// until the two stages behind it fill up. Write configuration only while no
// item is in flight.
// ----------------------------------------------------------------------------
module ewma_level_band_monitor (
	input  logic                         clk,
	input  logic                         arst_n,
	// sample channel
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [elbm_pkg::LEVEL_W-1:0] sample_level,
	input  logic                         sample_bad,
	// result channel
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [elbm_pkg::LEVEL_W-1:0] smoothed_level,
	output logic [elbm_pkg::BAND_W-1:0]  band_now,
	output logic [elbm_pkg::BAND_W-1:0]  band_before,
	output logic                         band_changed,
	// configuration port
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [elbm_pkg::ADDR_W-1:0]  paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);

	elbm_pkg::cfg_t             cfg;
	elbm_pkg::stage_t           st_s2;
	logic [elbm_pkg::ACC_W-1:0] acc_q;
	logic                       out_en;

	// register file: alpha, band count, six limits
	elbm_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// take the item, then advance the running average as it leaves stage one
	elbm_ewma u_ewma (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.sample_level (sample_level),
		.sample_bad   (sample_bad),
		.alpha        (cfg.alpha),
		.out_en       (out_en),
		.st_s2        (st_s2),
		.acc_q        (acc_q)
	);

	// classify the new average and hold the result until it is taken
	elbm_band u_band (
		.clk            (clk),
		.arst_n         (arst_n),
		.st_s2          (st_s2),
		.acc_q          (acc_q),
		.cfg            (cfg),
		.out_en         (out_en),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.smoothed_level (smoothed_level),
		.band_now       (band_now),
		.band_before    (band_before),
		.band_changed   (band_changed)
	);

	// a reported change always names two different bands
	a_chg_differs: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && band_changed) |-> (band_now != band_before))
		else $error("band change with equal bands");

	// no previous band can exist while there is no current band
	a_no_band_hist: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && band_now == elbm_pkg::NO_BAND) |->
		(band_before == elbm_pkg::NO_BAND))
		else $error("previous band set without a current band");

	// an empty result register never holds back the sample channel
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

endmodule

### hw/rtl/elbm_cfg_regs.sv
// ----------------------------------------------------------------------------
// elbm_cfg_regs: configuration register file
// APB-style write and read access to alpha, band count and band limits.
// ----------------------------------------------------------------------------
module elbm_cfg_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [elbm_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	output elbm_pkg::cfg_t              cfg
);

	logic                       wr_en;
	logic [elbm_pkg::IDX_W-1:0] idx;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign idx    = paddr[elbm_pkg::ADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.alpha      <= elbm_pkg::ALPHA_ONE;
			cfg.band_count <= '0;
			cfg.limit      <= '0;
		end else if (wr_en) begin
			if (idx == elbm_pkg::REG_ALPHA) begin
				cfg.alpha <= pwdata[elbm_pkg::ALPHA_W-1:0];
			end else if (idx == elbm_pkg::REG_COUNT) begin
				cfg.band_count <= pwdata[elbm_pkg::BAND_W-1:0];
			end else begin
				cfg.limit[idx - elbm_pkg::REG_LIMIT0] <= pwdata;
			end
		end
	end

	always_comb begin
		prdata = '0;
		if (idx == elbm_pkg::REG_ALPHA) begin
			prdata = 32'(cfg.alpha);
		end else if (idx == elbm_pkg::REG_COUNT) begin
			prdata = 32'(cfg.band_count);
		end else begin
			prdata = cfg.limit[idx - elbm_pkg::REG_LIMIT0];
		end
	end

endmodule

### hw/rtl/elbm_ewma.sv
// ----------------------------------------------------------------------------
// elbm_ewma: input register and exponentially weighted average update
// Holds the Q32.16 estimate and moves it toward each good sample.
// ----------------------------------------------------------------------------
module elbm_ewma (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [elbm_pkg::LEVEL_W-1:0] sample_level,
	input  logic                         sample_bad,
	input  logic [elbm_pkg::ALPHA_W-1:0] alpha,
	input  logic                         out_en,
	output elbm_pkg::stage_t             st_s2,
	output logic [elbm_pkg::ACC_W-1:0]   acc_q
);

	logic                         vld_s1;
	logic                         bad_s1;
	logic [elbm_pkg::LEVEL_W-1:0] level_s1;
	logic                         s1_en;
	logic                         s2_en;
	logic                         mv;
	logic [elbm_pkg::ALPHA_W-1:0] alpha_eff;
	logic [elbm_pkg::ACC_W-1:0]   target;
	logic                         up;
	logic [elbm_pkg::ACC_W-1:0]   mag;
	logic [elbm_pkg::ACC_W+elbm_pkg::ALPHA_W-1:0] prod;
	logic [elbm_pkg::ACC_W-1:0]   step_up;
	logic [elbm_pkg::ACC_W-1:0]   step_dn;
	logic [elbm_pkg::ACC_W-1:0]   acc_nxt;

	assign s2_en    = !st_s2.vld || out_en;
	assign s1_en    = !vld_s1 || s2_en;
	assign in_ready = s1_en;
	assign mv       = vld_s1 && s2_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s1_en) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_en && in_valid) begin
			level_s1 <= sample_level;
			bad_s1   <= sample_bad;
		end
	end

	always_comb begin
		alpha_eff = (alpha > elbm_pkg::ALPHA_ONE) ? elbm_pkg::ALPHA_ONE : alpha;
		target    = {level_s1, {elbm_pkg::FRAC_W{1'b0}}};
		up        = target >= acc_q;
		mag       = up ? (target - acc_q) : (acc_q - target);
		prod      = (elbm_pkg::ACC_W + elbm_pkg::ALPHA_W)'(mag) *
			(elbm_pkg::ACC_W + elbm_pkg::ALPHA_W)'(alpha_eff);
		// floor of the signed step: round the magnitude up when going down
		step_up   = prod[elbm_pkg::ACC_W+elbm_pkg::FRAC_W-1:elbm_pkg::FRAC_W];
		step_dn   = step_up + elbm_pkg::ACC_W'(|prod[elbm_pkg::FRAC_W-1:0]);
		acc_nxt   = up ? (acc_q + step_up) : (acc_q - step_dn);
	end

	// acc_q doubles as the stage-two payload: it only changes when s1 moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q     <= '0;
			st_s2.vld <= 1'b0;
			st_s2.bad <= 1'b0;
		end else if (s2_en) begin
			st_s2.vld <= vld_s1;
			st_s2.bad <= bad_s1;
			if (mv && !bad_s1) begin
				acc_q <= acc_nxt;
			end
		end
	end

endmodule

### hw/rtl/elbm_band.sv
// ----------------------------------------------------------------------------
// elbm_band: band classifier and result register
// Compares the estimate with the band limits and tracks current and previous band.
// ----------------------------------------------------------------------------
module elbm_band (
	input  logic                         clk,
	input  logic                         arst_n,
	input  elbm_pkg::stage_t             st_s2,
	input  logic [elbm_pkg::ACC_W-1:0]   acc_q,
	input  elbm_pkg::cfg_t               cfg,
	output logic                         out_en,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [elbm_pkg::LEVEL_W-1:0] smoothed_level,
	output logic [elbm_pkg::BAND_W-1:0]  band_now,
	output logic [elbm_pkg::BAND_W-1:0]  band_before,
	output logic                         band_changed
);

	logic                        mv;
	logic [elbm_pkg::BAND_W-1:0] n_used;
	logic                        hit;
	logic [elbm_pkg::BAND_W-1:0] hit_idx;
	logic [elbm_pkg::BAND_W-1:0] band_cur_q;
	logic [elbm_pkg::BAND_W-1:0] band_prev_q;
	logic                        chg;

	assign out_en = !out_valid || out_ready;
	assign mv     = st_s2.vld && out_en;

	always_comb begin
		n_used  = (cfg.band_count > elbm_pkg::BANDS_MAX) ? elbm_pkg::BANDS_MAX
			: cfg.band_count;
		hit     = 1'b0;
		hit_idx = elbm_pkg::NO_BAND;
		// six independent compares; lowest index wins
		for (int i = 0; i < elbm_pkg::MAX_BANDS; i++) begin
			if (!hit && (elbm_pkg::BAND_W'(i) < n_used) &&
				(acc_q <= {cfg.limit[i], {elbm_pkg::FRAC_W{1'b0}}})) begin
				hit     = 1'b1;
				hit_idx = elbm_pkg::BAND_W'(i);
			end
		end
		chg = !st_s2.bad && hit && (hit_idx != band_cur_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			band_cur_q  <= elbm_pkg::NO_BAND;
			band_prev_q <= elbm_pkg::NO_BAND;
			out_valid   <= 1'b0;
		end else begin
			if (out_en) begin
				out_valid <= st_s2.vld;
			end
			if (mv && chg) begin
				band_prev_q <= band_cur_q;
				band_cur_q  <= hit_idx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mv) begin
			smoothed_level <= acc_q[elbm_pkg::ACC_W-1:elbm_pkg::FRAC_W];
			band_now       <= chg ? hit_idx : band_cur_q;
			band_before    <= chg ? band_cur_q : band_prev_q;
			band_changed   <= chg;
		end
	end

endmodule
